// ===== hdl/kfb_pkg.sv =====
// shared types, widths, register codes and reset values of the kalman filter bank
package kfb_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int CHAN_FIELD_W  = 4;
    localparam int CHAN_VALUES   = 2 ** CHAN_FIELD_W;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int S_FIELDS_W    = CHAN_FIELD_W + DATA_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROCESS_NOISE = 2'd0,
        CFG_MEASURE_NOISE = 2'd1,
        CFG_RESTART_UNC   = 2'd2
    } cfg_idx_t;

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd9247601;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd18790482;
    localparam logic [DATA_W-1:0] RESTART_UNC_RST   = 32'd2684355;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/kfb_div.sv =====
// iterative restoring divider, one quotient bit a cycle, for the gain p*2^32/(p+r)
module kfb_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [kfb_pkg::DATA_W-1:0]    dividend,
    input  logic [kfb_pkg::DATA_W:0]      divisor,
    output logic [kfb_pkg::DATA_W-1:0]    quotient,
    output kfb_pkg::div_stat_t            stat
);
    import kfb_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W:0]     rem_reg;
    logic [DATA_W:0]     den_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DATA_W+1:0]   trial;
    logic [DATA_W+1:0]   diff;
    logic                fits;

    // remainder stays below the divisor, so the shifted value needs one more bit
    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[DATA_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= {1'b0, dividend};
                den_reg  <= divisor;
                quo_reg  <= '0;
                cnt_reg  <= CNT_W'(DATA_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DATA_W:0] : trial[DATA_W:0];
                quo_reg <= {quo_reg[DATA_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/kfb_mul.sv =====
// shared 32x32 unsigned multiplier with a registered product
module kfb_mul (
    input  logic                          aclk,
    input  logic [kfb_pkg::DATA_W-1:0]    op_a,
    input  logic [kfb_pkg::DATA_W-1:0]    op_b,
    output logic [kfb_pkg::PROD_W-1:0]    product
);
    import kfb_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign product = prod_reg;

endmodule

// ===== hdl/kalman_filter_bank_1d_unit.sv =====
// top level of the kalman filter bank: sequencer, channel stores and configuration
//
//  port group  direction  fields (low bit first)
//  s_*         in         tdata: channel[3:0], measurement[35:4], zero pad; tuser: restart
//  m_*         out        tdata: estimate[31:0]
//  cfg_*       in         cfg_index: register number, cfg_data: register value
//
// a filter step runs through load and predict, the gain division in the divider loop,
// two passes through the shared multiplier, write-back and output load. a restart item
// goes straight from accept to output load.
// aresetn is synchronous, active low; the channel stores need no clearing pass.
// s_tready is low while an item is in work; a result waiting on m_tready holds
// the sequencer in its output state, and the next item is taken once it has loaded.
module kalman_filter_bank_1d_unit #(
    parameter int CHANNELS = kfb_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kfb_pkg::S_TDATA_W-1:0]   s_tdata,   // channel, measurement, zero pad
    input  logic                            s_tuser,   // restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kfb_pkg::DATA_W-1:0]      m_tdata,   // estimate
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kfb_pkg::DATA_W-1:0]      cfg_data
);
    import kfb_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GAIN,
        ST_DIV,
        ST_MUL_CORR,
        ST_MUL_UNC,
        ST_WRITE,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [DATA_W-1:0]   q_reg;
    logic [DATA_W-1:0]   r_reg;
    logic [DATA_W-1:0]   u0_reg;
    logic                pending_reg;
    logic [DATA_W-1:0]   restart_val_reg;
    logic [CHANNELS-1:0] fresh_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [DATA_W-1:0]   z_reg;
    logic [DATA_W-1:0]   x_reg;
    logic [DATA_W-1:0]   p_reg;
    logic [DATA_W-1:0]   mag_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   k_reg;
    logic [DATA_W-1:0]   nx_reg;
    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;

    logic [DATA_W-1:0]   est_mem [CHANNELS];
    logic [DATA_W-1:0]   unc_mem [CHANNELS];
    logic [DATA_W-1:0]   est_rd_reg;
    logic [DATA_W-1:0]   unc_rd_reg;

    logic [CH_W-1:0]     wrap_tab [CHAN_VALUES];
    logic                in_accept;
    logic [CH_W-1:0]     in_ch;
    logic [DATA_W-1:0]   in_z;
    logic                ch_fresh;
    logic [DATA_W-1:0]   x_sel;
    logic [DATA_W-1:0]   p_sel;
    logic [DATA_W:0]     p_sum;
    logic [DATA_W-1:0]   p_pred;
    logic [DATA_W:0]     diff;
    logic [DATA_W:0]     diff_neg;
    logic [DATA_W:0]     den;
    logic                div_start;
    logic [DATA_W-1:0]   div_q;
    div_stat_t           div_stat;
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic [PROD_W-1:0]   product;
    logic [DATA_W-1:0]   cmag;
    logic [DATA_W+1:0]   corr;
    logic [DATA_W+1:0]   nx_wide;
    logic [DATA_W-1:0]   nx_sat;
    logic [DATA_W-1:0]   np;
    logic                out_free;

    // channel number taken modulo the bank size
    for (genvar g = 0; g < CHAN_VALUES; g++) begin : g_wrap
        assign wrap_tab[g] = CH_W'(g % CHANNELS);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_ch     = wrap_tab[s_tdata[CHAN_FIELD_W-1:0]];
    assign in_z      = s_tdata[CHAN_FIELD_W +: DATA_W];
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // a channel untouched since the last restart starts from the restart values
    assign ch_fresh = fresh_reg[ch_reg];
    assign x_sel    = ch_fresh ? restart_val_reg : est_rd_reg;
    assign p_sel    = ch_fresh ? u0_reg : unc_rd_reg;
    assign p_sum    = {1'b0, p_sel} + {1'b0, q_reg};
    assign p_pred   = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

    assign diff     = {z_reg[DATA_W-1], z_reg} - {x_reg[DATA_W-1], x_reg};
    assign diff_neg = -diff;
    assign den      = {1'b0, p_reg} + {1'b0, r_reg};
    assign div_start = (state_reg == ST_GAIN);

    kfb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (p_reg),
        .divisor  (den),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // first pass: |z-x|*k, second pass: (1-k)*p
    assign mul_a = (state_reg == ST_MUL_UNC) ? (~k_reg + 1'b1) : mag_reg;
    assign mul_b = (state_reg == ST_MUL_UNC) ? p_reg : k_reg;

    kfb_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    assign cmag    = product[PROD_W-1:DATA_W];
    assign corr    = neg_reg ? -{2'b00, cmag} : {2'b00, cmag};
    assign nx_wide = {{2{x_reg[DATA_W-1]}}, x_reg} + corr;

    always_comb begin
        if (nx_wide[DATA_W+1:DATA_W-1] == 3'b000 || nx_wide[DATA_W+1:DATA_W-1] == 3'b111) begin
            nx_sat = nx_wide[DATA_W-1:0];
        end else if (nx_wide[DATA_W+1]) begin
            nx_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            nx_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // a gain of zero leaves p as it is
    assign np = (k_reg == '0) ? p_reg : product[PROD_W-1:DATA_W];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            est_mem[ch_reg] <= nx_reg;
            unc_mem[ch_reg] <= np;
        end
        est_rd_reg <= est_mem[in_ch];
        unc_rd_reg <= unc_mem[in_ch];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            q_reg           <= PROCESS_NOISE_RST;
            r_reg           <= MEASURE_NOISE_RST;
            u0_reg          <= RESTART_UNC_RST;
            pending_reg     <= 1'b1;
            restart_val_reg <= '0;
            fresh_reg       <= '1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PROCESS_NOISE: q_reg  <= cfg_data;
                    CFG_MEASURE_NOISE: r_reg  <= cfg_data;
                    CFG_RESTART_UNC:   u0_reg <= cfg_data;
                    default: ;
                endcase
            end

            // in the output state the register is refilled there instead
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        ch_reg <= in_ch;
                        z_reg  <= in_z;
                        if (s_tuser || pending_reg) begin
                            pending_reg     <= 1'b0;
                            restart_val_reg <= in_z;
                            fresh_reg       <= '1;
                            nx_reg          <= in_z;
                            state_reg       <= ST_OUT;
                        end else begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    x_reg             <= x_sel;
                    p_reg             <= p_pred;
                    fresh_reg[ch_reg] <= 1'b0;
                    state_reg         <= ST_GAIN;
                end
                ST_GAIN: begin
                    mag_reg   <= diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
                    neg_reg   <= diff[DATA_W];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        // no measurement noise: gain just below one, or zero when p is zero
                        if (r_reg == '0) begin
                            k_reg <= (p_reg != '0) ? '1 : '0;
                        end else begin
                            k_reg <= div_q;
                        end
                        state_reg <= ST_MUL_CORR;
                    end
                end
                ST_MUL_CORR: begin
                    state_reg <= ST_MUL_UNC;
                end
                ST_MUL_UNC: begin
                    nx_reg    <= nx_sat;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= nx_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_restart_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !pending_reg)
        else $error("restart still pending after an item was taken");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while the previous item is in work");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the gain wait");
`endif

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the kalman filter bank: directed table, random phases, stalls
`timescale 1ns / 1ps

module tb;

    import kfb_pkg::*;

    localparam int      CHANNELS        = CHANNELS_DEF;
    localparam int      STEP_CYCLES     = 39;
    localparam int      SETTLE_CYCLES   = 4;
    localparam int      STALL_LIMIT     = 5000;
    localparam int      HOLD_OFF_CYCLES = 400;
    localparam int      RAND_PHASES     = 7;
    localparam int      PHASE_ITEMS     = 200;
    localparam int      ROWS            = 28;
    localparam longint  EST_MAX         = 64'sh0000_0000_7FFF_FFFF;
    localparam longint  EST_MIN         = -64'sh0000_0000_8000_0000;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [3:0]  chan;
        logic [31:0] value;      // measurement, or register data
        bit          restart;
        cfg_idx_t    reg_idx;
        bit          typed;
        logic [31:0] want;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // channel, measurement, zero pad
    logic                  s_tuser   = 1'b0; // restart
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // estimate
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_PROCESS_NOISE;
    logic [DATA_W-1:0]     cfg_data  = '0;

    // filter bank shadow state
    logic [31:0] noise_q       = PROCESS_NOISE_RST;
    logic [31:0] noise_r       = MEASURE_NOISE_RST;
    logic [31:0] rearm_p       = RESTART_UNC_RST;
    logic [31:0] chan_estimate [CHANNELS];
    logic [31:0] chan_uncert   [CHANNELS];
    bit          chan_fresh    [CHANNELS];
    logic [31:0] rearm_value   = '0;
    bit          rearm_pending = 1'b1;

    logic [31:0] expected_estimates [$];
    int          mismatch_count    = 0;
    int          stall_cycles      = 0;
    bit          hold_off_request  = 1'b0;

    stim_row_t directed_rows [ROWS] = '{
        '{ROW_ITEM, 4'd3,  32'h0001_2345, 1'b0, CFG_PROCESS_NOISE, 1'b1, 32'h0001_2345},
        '{ROW_ITEM, 4'd3,  32'h0002_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd15, 32'hFFFF_FFFF, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd0,  32'h7FFF_FFFF, 1'b1, CFG_PROCESS_NOISE, 1'b1, 32'h7FFF_FFFF},
        '{ROW_ITEM, 4'd0,  32'h8000_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd15, 32'h8000_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd15, 32'h8000_0000, 1'b1, CFG_PROCESS_NOISE, 1'b1, 32'h8000_0000},
        '{ROW_ITEM, 4'd7,  32'h7FFF_FFFF, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        // saturated prediction and a gain just below one
        '{ROW_CFG,  4'd0,  32'hFFFF_FFFF, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  32'h0000_0000, 1'b0, CFG_MEASURE_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd7,  32'h0000_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd9,  32'h1234_5678, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        // zero denominator
        '{ROW_CFG,  4'd0,  32'h0000_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  32'h0000_0000, 1'b0, CFG_RESTART_UNC,   1'b0, 32'h0},
        '{ROW_ITEM, 4'd0,  32'h0001_0000, 1'b1, CFG_PROCESS_NOISE, 1'b1, 32'h0001_0000},
        '{ROW_ITEM, 4'd2,  32'hFFFF_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd2,  32'h7FFF_FFFF, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  32'hFFFF_FFFF, 1'b0, CFG_MEASURE_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  32'hFFFF_FFFF, 1'b0, CFG_RESTART_UNC,   1'b0, 32'h0},
        '{ROW_ITEM, 4'd5,  32'h4000_0000, 1'b1, CFG_PROCESS_NOISE, 1'b1, 32'h4000_0000},
        '{ROW_ITEM, 4'd5,  32'hC000_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd5,  32'h0000_0000, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  PROCESS_NOISE_RST, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  MEASURE_NOISE_RST, 1'b0, CFG_MEASURE_NOISE, 1'b0, 32'h0},
        '{ROW_CFG,  4'd0,  RESTART_UNC_RST,   1'b0, CFG_RESTART_UNC,   1'b0, 32'h0},
        '{ROW_ITEM, 4'd10, 32'h5555_5555, 1'b1, CFG_PROCESS_NOISE, 1'b1, 32'h5555_5555},
        '{ROW_ITEM, 4'd10, 32'hAAAA_AAAA, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0},
        '{ROW_ITEM, 4'd5,  32'h5555_5555, 1'b0, CFG_PROCESS_NOISE, 1'b0, 32'h0}
    };

    kalman_filter_bank_1d_unit #(.CHANNELS(CHANNELS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            chan_fresh[i]    = 1'b1;
            chan_estimate[i] = '0;
            chan_uncert[i]   = '0;
        end
    end

    // one item through the shadow bank; returns the new estimate or the echoed measurement
    function automatic logic [31:0] filter_step(logic [3:0] chan, logic [31:0] z, bit restart);
        int unsigned c;
        logic [63:0] p, den, gain, mag, cmag, np;
        longint      x, zs, d, corr, nx;
        c = chan % CHANNELS;
        if (restart || rearm_pending) begin
            rearm_pending = 1'b0;
            rearm_value   = z;
            for (int i = 0; i < CHANNELS; i++)
                chan_fresh[i] = 1'b1;
            return z;
        end
        if (chan_fresh[c]) begin
            chan_fresh[c]    = 1'b0;
            chan_estimate[c] = rearm_value;
            chan_uncert[c]   = rearm_p;
        end
        p = chan_uncert[c] + noise_q;
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        den  = p + noise_r;
        gain = '0;
        if (den != 0) begin
            gain = (p << 32) / den;
            if (gain > 64'hFFFF_FFFF)
                gain = 64'hFFFF_FFFF;
        end
        x    = $signed(chan_estimate[c]);
        zs   = $signed(z);
        d    = zs - x;
        mag  = (d < 0) ? -d : d;
        // correction magnitude truncated, sign restored afterwards
        cmag = (mag * gain) >> 32;
        corr = cmag;
        if (d < 0)
            corr = -corr;
        nx = x + corr;
        if (nx > EST_MAX)
            nx = EST_MAX;
        if (nx < EST_MIN)
            nx = EST_MIN;
        np = ((64'h1_0000_0000 - gain) * p) >> 32;
        chan_estimate[c] = nx[31:0];
        chan_uncert[c]   = np[31:0];
        return chan_estimate[c];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        if (r < 4)
            return $urandom();
        return $urandom_range(0, 32'h1000_0000);
    endfunction

    task automatic send_item(logic [3:0] chan, logic [31:0] z, bit restart, int gap,
                             bit typed, logic [31:0] want);
        logic [31:0] predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, z, chan};
        s_tuser  <= restart;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = filter_step(chan, z, restart);
        expected_estimates.push_back(typed ? want : predicted);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [31:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_PROCESS_NOISE: noise_q = data;
            CFG_MEASURE_NOISE: noise_r = data;
            CFG_RESTART_UNC:   rearm_p = data;
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0)
                report_mismatch("unexpected estimate", m_tdata, 32'h0);
            else if (m_tdata !== expected_estimates[0])
                report_mismatch("estimate", m_tdata, expected_estimates.pop_front());
            else
                void'(expected_estimates.pop_front());
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int r;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else if (r < 70) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else if (r < 93) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(20, 200)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("kalman_filter_bank_1d_unit: mismatch");
        $finish;
    end

    initial begin
        logic [31:0] level, z;
        logic [3:0]  chan;
        bit          restart, gapless;
        int          gap;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CFG)
                    wait_idle();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].value,
                          i == ROWS - 1 || directed_rows[i+1].kind != ROW_CFG);
            end else begin
                send_item(directed_rows[i].chan, directed_rows[i].value,
                          directed_rows[i].restart, pick_gap(),
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            if (ph == 0) begin
                cfg_write(CFG_PROCESS_NOISE, PROCESS_NOISE_RST, 1'b0);
                cfg_write(CFG_MEASURE_NOISE, MEASURE_NOISE_RST, 1'b0);
                cfg_write(CFG_RESTART_UNC, RESTART_UNC_RST, 1'b1);
            end else begin
                cfg_write(CFG_PROCESS_NOISE, pick_noise(), 1'b0);
                cfg_write(CFG_MEASURE_NOISE, pick_noise(), 1'b0);
                cfg_write(CFG_RESTART_UNC, pick_noise(), 1'b1);
            end
            // long receiver stall while items keep coming
            if (ph == 3)
                hold_off_request = 1'b1;
            gapless = (ph == 1 || ph == 5);
            level   = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                chan    = $urandom_range(0, 15);
                restart = ($urandom_range(0, 99) < 3);
                // mostly a noisy signal around a level, some full-range values
                if ($urandom_range(0, 99) < 15)
                    z = $urandom();
                else
                    z = level + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                gap = gapless ? 0 : pick_gap();
                send_item(chan, z, restart, gap, 1'b0, 32'h0);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0)
            @(posedge aclk);
        repeat (2 * STEP_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("kalman_filter_bank_1d_unit: match");
        else
            $display("kalman_filter_bank_1d_unit: mismatch");
        $finish;
    end

endmodule
